@@ sv/pir_presence_qualifier_core_defines.svh @@
// ---------------------------------------------------------------------------
// PIR presence qualifier assertion macros
// Shared concurrent assertion forms used by the qualifier core.
// ---------------------------------------------------------------------------
`ifndef PIR_PRESENCE_QUALIFIER_CORE_DEFINES_SVH
`define PIR_PRESENCE_QUALIFIER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PIRQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PIRQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/pirq_pkg.sv @@
// ---------------------------------------------------------------------------
// PIR presence qualifier package
// Register map, reset values and shared types of the qualifier core.
// ---------------------------------------------------------------------------
package pirq_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 20;

   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WARMUP_TIME       = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SAMPLE_INTERVAL   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RETRIGGER_HOLDOFF = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RISE_CONFIRM_TIME = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FALL_CONFIRM_TIME = 3'd4;

   localparam logic [19:0] WARMUP_TIME_RESET       = 20'd30000;
   localparam logic [15:0] SAMPLE_INTERVAL_RESET   = 16'd50;
   localparam logic [19:0] RETRIGGER_HOLDOFF_RESET = 20'd2000;
   localparam logic [15:0] RISE_CONFIRM_TIME_RESET = 16'd200;
   localparam logic [19:0] FALL_CONFIRM_TIME_RESET = 20'd3000;

   typedef struct packed {
      logic [19:0] warmup_time;
      logic [15:0] sample_interval;
      logic [19:0] retrigger_holdoff;
      logic [15:0] rise_confirm_time;
      logic [19:0] fall_confirm_time;
   } cfg_type;

   typedef struct packed {
      logic presence;
      logic warmup_masking;
   } result_type;

endpackage

@@ sv/pirq_csr.sv @@
// ---------------------------------------------------------------------------
// PIR presence qualifier register file
// APB-style write/read access to the five timing registers.
// ---------------------------------------------------------------------------
module pirq_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pirq_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [pirq_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [pirq_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready,
   output pirq_pkg::cfg_type                    cfg
);

   pirq_pkg::cfg_type cfg_ff;
   logic [pirq_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic wr_en;

   assign index = csr_paddr[pirq_pkg::CSR_ADDR_WIDTH-1:2];
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.warmup_time       <= pirq_pkg::WARMUP_TIME_RESET;
         cfg_ff.sample_interval   <= pirq_pkg::SAMPLE_INTERVAL_RESET;
         cfg_ff.retrigger_holdoff <= pirq_pkg::RETRIGGER_HOLDOFF_RESET;
         cfg_ff.rise_confirm_time <= pirq_pkg::RISE_CONFIRM_TIME_RESET;
         cfg_ff.fall_confirm_time <= pirq_pkg::FALL_CONFIRM_TIME_RESET;
      end else if (wr_en) begin
         case (index)
            pirq_pkg::CSR_WARMUP_TIME:       cfg_ff.warmup_time       <= csr_pwdata[19:0];
            pirq_pkg::CSR_SAMPLE_INTERVAL:   cfg_ff.sample_interval   <= csr_pwdata[15:0];
            pirq_pkg::CSR_RETRIGGER_HOLDOFF: cfg_ff.retrigger_holdoff <= csr_pwdata[19:0];
            pirq_pkg::CSR_RISE_CONFIRM_TIME: cfg_ff.rise_confirm_time <= csr_pwdata[15:0];
            pirq_pkg::CSR_FALL_CONFIRM_TIME: cfg_ff.fall_confirm_time <= csr_pwdata[19:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         pirq_pkg::CSR_WARMUP_TIME:       csr_prdata = 32'(cfg_ff.warmup_time);
         pirq_pkg::CSR_SAMPLE_INTERVAL:   csr_prdata = 32'(cfg_ff.sample_interval);
         pirq_pkg::CSR_RETRIGGER_HOLDOFF: csr_prdata = 32'(cfg_ff.retrigger_holdoff);
         pirq_pkg::CSR_RISE_CONFIRM_TIME: csr_prdata = 32'(cfg_ff.rise_confirm_time);
         pirq_pkg::CSR_FALL_CONFIRM_TIME: csr_prdata = 32'(cfg_ff.fall_confirm_time);
         default:                         csr_prdata = '0;
      endcase
   end

endmodule

@@ sv/pirq_qualifier.sv @@
// ---------------------------------------------------------------------------
// PIR presence qualifier state
// Mode machine and saturating elapsed counters, stepped once per tick item.
// ---------------------------------------------------------------------------
module pirq_qualifier #(
   parameter int COUNT_WIDTH = pirq_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pirq_pkg::cfg_type    cfg,
   input  logic                 step,
   input  logic                 raw_level,
   output pirq_pkg::result_type result
);

   localparam int CmpWidth = (COUNT_WIDTH > 20) ? COUNT_WIDTH : 20;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_RISE   = 2'd1,
      MODE_ACTIVE = 2'd2,
      MODE_FALL   = 2'd3
   } mode_type;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   mode_type  mode_ff, mode_in;
   count_type since_reset_ff, since_reset_in;
   count_type since_sample_ff, since_sample_in;
   count_type since_entry_ff, since_entry_in;
   count_type since_release_ff, since_release_in;

   logic warmup_active, sample_due, holdoff_met, rise_met, fall_met;
   logic entry_restart, release_restart, sample_restart;

   function automatic count_type count_up(input count_type c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   // Counters and registers are compared on a common width; a register value
   // beyond the counter range is simply never reached.
   assign warmup_active = CmpWidth'(since_reset_ff) < CmpWidth'(cfg.warmup_time);
   assign sample_due    = CmpWidth'(since_sample_ff) >= CmpWidth'(cfg.sample_interval);
   assign holdoff_met   = CmpWidth'(since_release_ff) >= CmpWidth'(cfg.retrigger_holdoff);
   assign rise_met      = CmpWidth'(since_entry_ff) >= CmpWidth'(cfg.rise_confirm_time);
   assign fall_met      = CmpWidth'(since_entry_ff) >= CmpWidth'(cfg.fall_confirm_time);

   always_comb begin
      mode_in         = mode_ff;
      entry_restart   = 1'b0;
      release_restart = 1'b0;
      sample_restart  = 1'b0;
      if (warmup_active) begin
         mode_in       = MODE_IDLE;
         entry_restart = 1'b1;
      end else if (sample_due) begin
         sample_restart = 1'b1;
         case (mode_ff)
            MODE_IDLE: begin
               if (raw_level && holdoff_met) mode_in = MODE_RISE;
            end
            MODE_RISE: begin
               if (!raw_level) mode_in = MODE_IDLE;
               else if (rise_met) mode_in = MODE_ACTIVE;
            end
            MODE_ACTIVE: begin
               if (!raw_level) mode_in = MODE_FALL;
            end
            MODE_FALL: begin
               if (raw_level) begin
                  mode_in = MODE_ACTIVE;
               end else if (fall_met) begin
                  mode_in         = MODE_IDLE;
                  release_restart = 1'b1;
               end
            end
            default: mode_in = MODE_IDLE;
         endcase
         if (mode_in != mode_ff) entry_restart = 1'b1;
      end
   end

   // A restarted counter still advances at the end of the tick.
   assign since_reset_in   = count_up(since_reset_ff);
   assign since_sample_in  = count_up(sample_restart ? '0 : since_sample_ff);
   assign since_entry_in   = count_up(entry_restart ? '0 : since_entry_ff);
   assign since_release_in = count_up(release_restart ? '0 : since_release_ff);

   assign result.presence       = (mode_in == MODE_ACTIVE) || (mode_in == MODE_FALL);
   assign result.warmup_masking = warmup_active;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_IDLE;
         since_reset_ff   <= '0;
         since_sample_ff  <= '0;
         since_entry_ff   <= '0;
         since_release_ff <= '0;
      end else if (step) begin
         mode_ff          <= mode_in;
         since_reset_ff   <= since_reset_in;
         since_sample_ff  <= since_sample_in;
         since_entry_ff   <= since_entry_in;
         since_release_ff <= since_release_in;
      end
   end

endmodule

@@ sv/pir_presence_qualifier_core.sv @@
// ---------------------------------------------------------------------------
// PIR presence qualifier core
// Pipeline: an accepted item waits in the s1 register, then is stepped into the result register.
// Throughput: one item per cycle while rsp_ready holds, set by the single-pass qualifier step.
// Reset: synchronous; clears the pipeline, mode and counters, restores registers.
// ---------------------------------------------------------------------------
`include "pir_presence_qualifier_core_defines.svh"

module pir_presence_qualifier_core #(
   parameter int COUNT_WIDTH = pirq_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_raw_level,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_presence,
   output logic                                 rsp_warmup_masking,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pirq_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [pirq_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [pirq_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready
);

   pirq_pkg::cfg_type    cfg;
   pirq_pkg::result_type step_result;

   logic s1_valid_ff, s1_raw_ff;
   logic rsp_valid_ff;
   pirq_pkg::result_type rsp_result_ff;
   logic advance;

   pirq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pirq_qualifier #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_qualifier (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step      (advance),
      .raw_level (s1_raw_ff),
      .result    (step_result)
   );

   // The registered item moves on whenever the result register is free or
   // is being emptied in this cycle.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) s1_valid_ff <= req_valid;
         if (advance) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) s1_raw_ff <= req_raw_level;
      if (advance) rsp_result_ff <= step_result;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_presence       = rsp_result_ff.presence;
   assign rsp_warmup_masking = rsp_result_ff.warmup_masking;

   `PIRQ_ASSERT_SAME(a_mask_blocks_presence, clock, reset, rsp_valid_ff && rsp_result_ff.warmup_masking, !rsp_result_ff.presence, "presence reported during warm-up")
   `PIRQ_ASSERT_NEXT(a_step_fills_result, clock, reset, advance, rsp_valid_ff, "stepped item did not reach the result register")
   `PIRQ_ASSERT_NEXT(a_stalled_item_kept, clock, reset, s1_valid_ff && !advance, s1_valid_ff && $stable(s1_raw_ff), "waiting item lost or changed")

endmodule

@@ tb/pir_presence_qualifier_core_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// PIR presence qualifier core testbench
// Feeds millisecond ticks with run-length sensor patterns through a series of
// register settings, predicts presence and warm-up masking per tick, and
// compares every result in order; both handshakes stall at random but in the last two phases.
// ---------------------------------------------------------------------------
module pir_presence_qualifier_core_test;

   localparam int CW = pirq_pkg::COUNT_WIDTH_DEFAULT;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS = 156;
   localparam int EXTREME_ITEMS = 30;
   localparam int SETTLE_CYCLES = 4;
   localparam int WATCHDOG_LIMIT = 1000;

   // Directed level patterns, applied from bit 0 upward.
   localparam logic [11:0] ZERO_TIME_LEVELS = 12'b1110_0100_1011;
   localparam logic [9:0] SLOW_SAMPLE_LEVELS = 10'b00_1111_1111;

   typedef logic [CW-1:0] count_type;
   typedef logic [pirq_pkg::CSR_INDEX_WIDTH-1:0] reg_index_type;

   typedef enum logic [1:0] {
      MODE_IDLE         = 2'd0,
      MODE_RISE_CONFIRM = 2'd1,
      MODE_ACTIVE       = 2'd2,
      MODE_FALL_CONFIRM = 2'd3
   } qual_mode_type;

   class presence_tracker;
      pirq_pkg::cfg_type settings;
      qual_mode_type mode;
      count_type since_reset;
      count_type since_sample;
      count_type since_entry;
      count_type since_release;
      pirq_pkg::result_type expected_q[$];
      int unsigned errors;

      function new();
         settings.warmup_time = pirq_pkg::WARMUP_TIME_RESET;
         settings.sample_interval = pirq_pkg::SAMPLE_INTERVAL_RESET;
         settings.retrigger_holdoff = pirq_pkg::RETRIGGER_HOLDOFF_RESET;
         settings.rise_confirm_time = pirq_pkg::RISE_CONFIRM_TIME_RESET;
         settings.fall_confirm_time = pirq_pkg::FALL_CONFIRM_TIME_RESET;
         mode = MODE_IDLE;
         since_reset = '0;
         since_sample = '0;
         since_entry = '0;
         since_release = '0;
         errors = 0;
      endfunction

      function void set_register(reg_index_type index,
                                 logic [pirq_pkg::CSR_DATA_WIDTH-1:0] data);
         case (index)
            pirq_pkg::CSR_WARMUP_TIME: settings.warmup_time = data[19:0];
            pirq_pkg::CSR_SAMPLE_INTERVAL: settings.sample_interval = data[15:0];
            pirq_pkg::CSR_RETRIGGER_HOLDOFF: settings.retrigger_holdoff = data[19:0];
            pirq_pkg::CSR_RISE_CONFIRM_TIME: settings.rise_confirm_time = data[15:0];
            pirq_pkg::CSR_FALL_CONFIRM_TIME: settings.fall_confirm_time = data[19:0];
            default: ;
         endcase
      endfunction

      function void switch_mode(qual_mode_type next_mode);
         mode = next_mode;
         since_entry = '0;
      endfunction

      function count_type bump(count_type value);
         return (value == '1) ? value : value + 1'b1;
      endfunction

      function void note_tick(logic raw_level);
         pirq_pkg::result_type want;
         logic masking;
         masking = 1'b0;
         if (since_reset < settings.warmup_time) begin
            switch_mode(MODE_IDLE);
            masking = 1'b1;
         end else if (since_sample >= settings.sample_interval) begin
            since_sample = '0;
            case (mode)
               MODE_IDLE: begin
                  if (raw_level && since_release >= settings.retrigger_holdoff)
                     switch_mode(MODE_RISE_CONFIRM);
               end
               MODE_RISE_CONFIRM: begin
                  if (!raw_level)
                     switch_mode(MODE_IDLE);
                  else if (since_entry >= settings.rise_confirm_time)
                     switch_mode(MODE_ACTIVE);
               end
               MODE_ACTIVE: begin
                  if (!raw_level)
                     switch_mode(MODE_FALL_CONFIRM);
               end
               default: begin
                  if (raw_level) begin
                     switch_mode(MODE_ACTIVE);
                  end else if (since_entry >= settings.fall_confirm_time) begin
                     switch_mode(MODE_IDLE);
                     since_release = '0;
                  end
               end
            endcase
         end
         want.presence = (mode == MODE_ACTIVE || mode == MODE_FALL_CONFIRM);
         want.warmup_masking = masking;
         expected_q.push_back(want);
         since_reset = bump(since_reset);
         since_sample = bump(since_sample);
         since_entry = bump(since_entry);
         since_release = bump(since_release);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void check_result(logic presence, logic warmup_masking);
         pirq_pkg::result_type want;
         if (expected_q.size() == 0) begin
            $error("result with no item outstanding: presence %0b, warmup_masking %0b",
                   presence, warmup_masking);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (presence !== want.presence) begin
            $error("presence: expected %0b, actual %0b", want.presence, presence);
            errors++;
         end
         if (warmup_masking !== want.warmup_masking) begin
            $error("warmup_masking: expected %0b, actual %0b",
                   want.warmup_masking, warmup_masking);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_raw_level = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_presence;
   logic rsp_warmup_masking;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [pirq_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [pirq_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [pirq_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   presence_tracker tracker;
   bit gaps_on = 1'b1;
   int stall_left = 0;
   int quiet_cycles = 0;
   logic run_level = 1'b0;
   int run_left = 0;
   int run_span = 8;

   pir_presence_qualifier_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_result(rsp_presence, rsp_warmup_masking);
   end

   // The receiver stalls in bursts while idling is enabled.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 7) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("pir_presence_qualifier_core: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_level(input logic level);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raw_level <= level;
      do @(posedge clock); while (!req_ready);
      tracker.note_tick(level);
   endtask

   // Waits until every tick has produced its result, with the sender idle.
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input reg_index_type index,
                                 input logic [pirq_pkg::CSR_DATA_WIDTH-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.set_register(index, data);
   endtask

   task automatic end_register_writes();
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Sometimes sets bits above the register width, which must be dropped.
   function automatic logic [pirq_pkg::CSR_DATA_WIDTH-1:0] with_junk(
         logic [pirq_pkg::CSR_DATA_WIDTH-1:0] value, int width);
      logic [pirq_pkg::CSR_DATA_WIDTH-1:0] upper;
      upper = ~((32'h1 << width) - 32'h1);
      if ($urandom_range(0, 3) == 0)
         return value | ($urandom() & upper);
      return value;
   endfunction

   task automatic apply_settings(input pirq_pkg::cfg_type s);
      write_register(pirq_pkg::CSR_WARMUP_TIME, with_junk(32'(s.warmup_time), 20));
      write_register(pirq_pkg::CSR_SAMPLE_INTERVAL, with_junk(32'(s.sample_interval), 16));
      write_register(pirq_pkg::CSR_RETRIGGER_HOLDOFF,
                     with_junk(32'(s.retrigger_holdoff), 20));
      write_register(pirq_pkg::CSR_RISE_CONFIRM_TIME,
                     with_junk(32'(s.rise_confirm_time), 16));
      write_register(pirq_pkg::CSR_FALL_CONFIRM_TIME,
                     with_junk(32'(s.fall_confirm_time), 20));
      end_register_writes();
   endtask

   // Short confirm times keep the mode machine moving within a phase. A warm-up
   // beyond the elapsed tick count masks the sensor again for a while.
   function automatic pirq_pkg::cfg_type pick_settings();
      pirq_pkg::cfg_type s;
      s.sample_interval = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
      s.rise_confirm_time = 16'($urandom_range(0, 24));
      s.fall_confirm_time = 20'($urandom_range(0, 40));
      s.retrigger_holdoff = 20'($urandom_range(0, 40));
      case ($urandom_range(0, 9))
         0, 1: s.warmup_time = 20'(tracker.since_reset) + 20'($urandom_range(1, 24));
         2: s.warmup_time = 20'($urandom());
         3, 4: s.warmup_time = 20'($urandom_range(0, int'(tracker.since_reset)));
         default: s.warmup_time = '0;
      endcase
      return s;
   endfunction

   // Alternating runs: mostly long enough to confirm, some short glitches.
   function automatic logic next_level();
      if (run_left == 0) begin
         run_level = ~run_level;
         run_left = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 3)
                                               : $urandom_range(1, run_span);
      end
      run_left--;
      return run_level;
   endfunction

   task automatic run_phase(input int count);
      run_span = (int'(tracker.settings.rise_confirm_time)
                  + int'(tracker.settings.fall_confirm_time) + 4)
                 * (int'(tracker.settings.sample_interval) + 1);
      if (run_span > 300)
         run_span = 300;
      for (int i = 0; i < count; i++)
         push_level(next_level());
   endtask

   initial begin
      pirq_pkg::cfg_type s;
      tracker = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: the long default warm-up masks every tick.
      for (int i = 0; i < 4; i++)
         push_level(1'(i));
      settle();

      // All times zero: every tick is evaluated and every transition is immediate.
      apply_settings('0);
      for (int i = 0; i < 12; i++)
         push_level(ZERO_TIME_LEVELS[i]);
      settle();

      // Writes past the last register must change nothing.
      for (int i = pirq_pkg::CSR_FALL_CONFIRM_TIME + 1;
           i < 2 ** pirq_pkg::CSR_INDEX_WIDTH; i++)
         write_register(reg_index_type'(i), $urandom());
      end_register_writes();

      // Warm-up re-entered for three ticks, then sampling on every tick.
      s.warmup_time = 20'(tracker.since_reset) + 20'd3;
      s.sample_interval = 16'd1;
      s.retrigger_holdoff = 20'd4;
      s.rise_confirm_time = 16'd2;
      s.fall_confirm_time = 20'd2;
      apply_settings(s);
      for (int i = 0; i < 10; i++)
         push_level(SLOW_SAMPLE_LEVELS[i]);
      settle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         gaps_on = (p < RANDOM_PHASES - 2);
         if (p == 3) begin
            for (int i = pirq_pkg::CSR_WARMUP_TIME; i <= pirq_pkg::CSR_FALL_CONFIRM_TIME; i++)
               write_register(reg_index_type'(i), '1);
            end_register_writes();
            run_phase(EXTREME_ITEMS);
         end else if (p == 4) begin
            s = '1;
            s.warmup_time = '0;
            apply_settings(s);
            run_phase(EXTREME_ITEMS);
         end else begin
            apply_settings(pick_settings());
            run_phase(PHASE_ITEMS);
         end
         settle();
      end

      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("pir_presence_qualifier_core: match");
      else
         $display("pir_presence_qualifier_core: mismatch");
      $finish;
   end

endmodule
